>>> design/tose_pkg.sv
// Shared constants for the typed operand stack engine: sizes, operation, type and status codes.
`timescale 1ns / 1ps
package tose_pkg;

	localparam int DefStackDepth = 64;
	localparam int DefValueWidth = 32;

	localparam logic [3:0] K_PUSH        = 4'd0;
	localparam logic [3:0] K_POP         = 4'd1;
	localparam logic [3:0] K_EXCH        = 4'd2;
	localparam logic [3:0] K_DUP         = 4'd3;
	localparam logic [3:0] K_COPY        = 4'd4;
	localparam logic [3:0] K_INDEX       = 4'd5;
	localparam logic [3:0] K_ROLL        = 4'd6;
	localparam logic [3:0] K_CLEAR       = 4'd7;
	localparam logic [3:0] K_COUNT       = 4'd8;
	localparam logic [3:0] K_MARK        = 4'd9;
	localparam logic [3:0] K_COUNTTOMARK = 4'd10;
	localparam logic [3:0] K_CLEARTOMARK = 4'd11;

	localparam logic [2:0] T_NULL = 3'd0;
	localparam logic [2:0] T_INT  = 3'd1;
	localparam logic [2:0] T_MARK = 3'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDER     = 3'd1;
	localparam logic [2:0] ST_OVER      = 3'd2;
	localparam logic [2:0] ST_TYPE      = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;
	localparam logic [2:0] ST_UNMATCHED = 3'd5;

endpackage

>>> design/typed_operand_stack_engine.sv
// Typed operand stack engine: stack memory, operation sequencer and result register.
`timescale 1ns / 1ps
// The command channel (cmd_valid, cmd_stall) takes one operation per beat: kind,
// push_type and push_value. The response channel (rsp_valid, rsp_stall) returns
// one beat per operation with status, depth and the new top item (top_type and
// top_value are zero when the stack is empty).
// The stack lives in one synchronous memory with a registered read; a sequencer
// reads, modifies and writes it back one entry per access. A command is taken
// only while the sequencer is idle, so one operation is in flight at a time.
// Push, pop, dup, clear, count, mark and unknown kinds finish in the state that sees
// the top entry; index then reads the chosen entry and writes it in place of the top;
// exch writes both entries back swapped; copy n reads and writes each copied entry in
// turn; counttomark and cleartomark read entries downward until a mark; roll n j first
// finds j mod n bit-serially, then swaps entries pairwise in three reversals to rotate.
// The single memory port and the bit-serial remainder shape these steps.
// Reset clears the depth and the control state; the memory contents stay
// undefined, which is harmless since only entries below the depth are used.
// A stalled response holds in the output register; the sequencer waits there
// with its finished result and takes no new command until the beat leaves.
module typed_operand_stack_engine
	import tose_pkg::*;
#(
	parameter int STACK_DEPTH = DefStackDepth,
	parameter int VALUE_WIDTH = DefValueWidth,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic [3:0]             kind,
	input  logic [2:0]             push_type,
	input  logic [VALUE_WIDTH-1:0] push_value,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [2:0]             status,
	output logic [CW-1:0]          depth,
	output logic                   top_valid,
	output logic [2:0]             top_type,
	output logic [VALUE_WIDTH-1:0] top_value
);

	localparam int VW = VALUE_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int EW = VW + 3;
	localparam int XW = ((VW > CW) ? VW : CW) + 2;
	localparam int BW = $clog2(VW + 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_OP   = 5'd1;
	localparam logic [4:0] S_EX1  = 5'd2;
	localparam logic [4:0] S_EX2  = 5'd3;
	localparam logic [4:0] S_CPR  = 5'd4;
	localparam logic [4:0] S_CPW  = 5'd5;
	localparam logic [4:0] S_IX   = 5'd6;
	localparam logic [4:0] S_RL1  = 5'd7;
	localparam logic [4:0] S_DIV  = 5'd8;
	localparam logic [4:0] S_RADJ = 5'd9;
	localparam logic [4:0] S_RVA  = 5'd10;
	localparam logic [4:0] S_RVB  = 5'd11;
	localparam logic [4:0] S_RVC  = 5'd12;
	localparam logic [4:0] S_RVD  = 5'd13;
	localparam logic [4:0] S_SCR  = 5'd14;
	localparam logic [4:0] S_SCC  = 5'd15;
	localparam logic [4:0] S_FT   = 5'd16;
	localparam logic [4:0] S_RS   = 5'd17;

	localparam logic [CW-1:0] FullCount = CW'(STACK_DEPTH);

	// Stack memory: type tag in the upper bits, value word below.
	logic [EW-1:0] mem [STACK_DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] ra, wa;
	logic          we;
	logic [EW-1:0] wd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	logic [4:0]    state_q, state_d;
	logic [3:0]    kind_q, kind_d;
	logic [2:0]    ptype_q, ptype_d;
	logic [VW-1:0] pval_q, pval_d;
	logic [2:0]    st_q, st_d;
	logic [CW-1:0] count_q, count_d;
	logic [EW-1:0] a_q, a_d;
	logic [CW-1:0] src_q, src_d, dst_q, dst_d, left_q, left_d;
	logic [CW-1:0] n_q, n_d, r_q, r_d, base_q, base_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
	logic [1:0]    ph_q, ph_d;
	logic [VW-1:0] jmag_q, jmag_d;
	logic          jneg_q, jneg_d;
	logic [BW-1:0] bit_q, bit_d;

	logic          rsp_valid_q;
	logic [2:0]    status_q;
	logic [CW-1:0] depth_q;
	logic          top_valid_q;
	logic [2:0]    top_type_q;
	logic [VW-1:0] top_value_q;
	logic          rsp_load;

	// Fields of the word that the memory returned this cycle.
	logic [2:0]    rd_t;
	logic [VW-1:0] rd_v;
	logic [XW-1:0] nx, cntx;
	logic [CW-1:0] n_c;
	logic [CW:0]   div_sh;
	logic          full;

	assign rd_t = rd_q[EW-1:VW];
	assign rd_v = rd_q[VW-1:0];
	assign nx   = XW'(rd_v);
	assign cntx = XW'(count_q);
	assign n_c  = nx[CW-1:0];
	assign full = (count_q == FullCount);
	assign div_sh = {r_q, jmag_q[VW-1]};

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		ptype_d = ptype_q;
		pval_d  = pval_q;
		st_d    = st_q;
		count_d = count_q;
		a_d     = a_q;
		src_d   = src_q;
		dst_d   = dst_q;
		left_d  = left_q;
		n_d     = n_q;
		r_d     = r_q;
		base_d  = base_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		idx_d   = idx_q;
		ph_d    = ph_q;
		jmag_d  = jmag_q;
		jneg_d  = jneg_q;
		bit_d   = bit_q;
		rsp_load = 1'b0;
		ra = AW'(count_q - 1'b1);
		we = 1'b0;
		wa = AW'(count_q);
		wd = rd_q;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					kind_d  = kind;
					ptype_d = push_type;
					pval_d  = push_value;
					st_d    = ST_OK;
					state_d = S_OP;
				end
			end
			S_OP: begin
				// rd_q holds the top entry when the stack is not empty.
				state_d = S_FT;
				case (kind_q)
					K_PUSH: begin
						if (full) begin
							st_d = ST_OVER;
						end else begin
							we = 1'b1;
							wd = {ptype_q, pval_q};
							count_d = count_q + 1'b1;
						end
					end
					K_POP: begin
						if (count_q == '0) st_d = ST_UNDER;
						else count_d = count_q - 1'b1;
					end
					K_EXCH: begin
						if (count_q < CW'(2)) begin
							st_d = ST_UNDER;
						end else begin
							a_d = rd_q;
							ra = AW'(count_q - CW'(2));
							state_d = S_EX1;
						end
					end
					K_DUP: begin
						if (count_q == '0) begin
							st_d = ST_UNDER;
						end else if (full) begin
							st_d = ST_OVER;
						end else begin
							we = 1'b1;
							wd = rd_q;
							count_d = count_q + 1'b1;
						end
					end
					K_COPY: begin
						if (count_q == '0) st_d = ST_UNDER;
						else if (rd_t != T_INT) st_d = ST_TYPE;
						else if (rd_v[VW-1]) st_d = ST_RANGE;
						else if (nx + XW'(1) > cntx) st_d = ST_UNDER;
						else if (cntx - XW'(1) + nx > XW'(STACK_DEPTH)) st_d = ST_OVER;
						else begin
							count_d = count_q - 1'b1;
							src_d   = count_q - 1'b1 - n_c;
							dst_d   = count_q - 1'b1;
							left_d  = n_c;
							state_d = S_CPR;
						end
					end
					K_INDEX: begin
						if (count_q == '0) st_d = ST_UNDER;
						else if (rd_t != T_INT) st_d = ST_TYPE;
						else if (rd_v[VW-1]) st_d = ST_RANGE;
						else if (nx + XW'(2) > cntx) st_d = ST_UNDER;
						else begin
							ra = AW'(count_q - CW'(2) - n_c);
							state_d = S_IX;
						end
					end
					K_ROLL: begin
						if (count_q < CW'(2)) begin
							st_d = ST_UNDER;
						end else begin
							a_d = rd_q;
							ra = AW'(count_q - CW'(2));
							state_d = S_RL1;
						end
					end
					K_CLEAR: count_d = '0;
					K_COUNT: begin
						if (full) begin
							st_d = ST_OVER;
						end else begin
							we = 1'b1;
							wd = {T_INT, VW'(count_q)};
							count_d = count_q + 1'b1;
						end
					end
					K_MARK: begin
						if (full) begin
							st_d = ST_OVER;
						end else begin
							we = 1'b1;
							wd = {T_MARK, {VW{1'b0}}};
							count_d = count_q + 1'b1;
						end
					end
					K_COUNTTOMARK: begin
						if (full) begin
							st_d = ST_OVER;
						end else begin
							idx_d = count_q;
							state_d = S_SCR;
						end
					end
					K_CLEARTOMARK: begin
						idx_d = count_q;
						state_d = S_SCR;
					end
					default: ;
				endcase
			end
			S_EX1: begin
				// rd_q is the second entry; it becomes the top.
				we = 1'b1;
				wa = AW'(count_q - 1'b1);
				wd = rd_q;
				state_d = S_EX2;
			end
			S_EX2: begin
				we = 1'b1;
				wa = AW'(count_q - CW'(2));
				wd = a_q;
				state_d = S_FT;
			end
			S_CPR: begin
				if (left_q == '0) begin
					state_d = S_FT;
				end else begin
					ra = AW'(src_q);
					state_d = S_CPW;
				end
			end
			S_CPW: begin
				we = 1'b1;
				wa = AW'(dst_q);
				wd = rd_q;
				src_d = src_q + 1'b1;
				dst_d = dst_q + 1'b1;
				left_d = left_q - 1'b1;
				count_d = count_q + 1'b1;
				state_d = S_CPR;
			end
			S_IX: begin
				we = 1'b1;
				wa = AW'(count_q - 1'b1);
				wd = rd_q;
				state_d = S_FT;
			end
			S_RL1: begin
				// a_q holds j from the top, rd_q holds n from below it.
				state_d = S_FT;
				if (a_q[EW-1:VW] != T_INT || rd_t != T_INT) st_d = ST_TYPE;
				else if (rd_v[VW-1]) st_d = ST_RANGE;
				else if (nx + XW'(2) > cntx) st_d = ST_UNDER;
				else begin
					count_d = count_q - CW'(2);
					if (n_c != '0) begin
						n_d    = n_c;
						jneg_d = a_q[VW-1];
						jmag_d = a_q[VW-1] ? (~a_q[VW-1:0] + 1'b1) : a_q[VW-1:0];
						r_d    = '0;
						bit_d  = BW'(VW);
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				// Restoring remainder, one bit of |j| per cycle.
				if (div_sh >= {1'b0, n_q}) r_d = CW'(div_sh - {1'b0, n_q});
				else r_d = div_sh[CW-1:0];
				jmag_d = jmag_q << 1;
				bit_d = bit_q - 1'b1;
				if (bit_q == BW'(1)) state_d = S_RADJ;
			end
			S_RADJ: begin
				// Rotation toward the top by r: reverse all, then the first r, then the rest.
				if (jneg_q && r_q != '0) r_d = n_q - r_q;
				base_d = count_q - n_q;
				lo_d = count_q - n_q;
				hi_d = count_q - 1'b1;
				ph_d = 2'd0;
				if (r_q == '0) state_d = S_FT;
				else state_d = S_RVA;
			end
			S_RVA: begin
				if (lo_q >= hi_q) begin
					case (ph_q)
						2'd0: begin
							lo_d = base_q;
							hi_d = base_q + r_q - 1'b1;
							ph_d = 2'd1;
						end
						2'd1: begin
							lo_d = base_q + r_q;
							hi_d = base_q + n_q - 1'b1;
							ph_d = 2'd2;
						end
						default: state_d = S_FT;
					endcase
				end else begin
					ra = AW'(lo_q);
					state_d = S_RVB;
				end
			end
			S_RVB: begin
				a_d = rd_q;
				ra = AW'(hi_q);
				state_d = S_RVC;
			end
			S_RVC: begin
				we = 1'b1;
				wa = AW'(lo_q);
				wd = rd_q;
				state_d = S_RVD;
			end
			S_RVD: begin
				we = 1'b1;
				wa = AW'(hi_q);
				wd = a_q;
				lo_d = lo_q + 1'b1;
				hi_d = hi_q - 1'b1;
				state_d = S_RVA;
			end
			S_SCR: begin
				if (idx_q == '0) begin
					st_d = ST_UNMATCHED;
					state_d = S_FT;
				end else begin
					ra = AW'(idx_q - 1'b1);
					state_d = S_SCC;
				end
			end
			S_SCC: begin
				if (rd_t == T_MARK) begin
					state_d = S_FT;
					if (kind_q == K_COUNTTOMARK) begin
						we = 1'b1;
						wd = {T_INT, VW'(count_q - idx_q)};
						count_d = count_q + 1'b1;
					end else begin
						count_d = idx_q - 1'b1;
					end
				end else begin
					idx_d = idx_q - 1'b1;
					state_d = S_SCR;
				end
			end
			S_FT: state_d = S_RS;
			S_RS: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		ptype_q <= ptype_d;
		pval_q  <= pval_d;
		st_q    <= st_d;
		a_q     <= a_d;
		src_q   <= src_d;
		dst_q   <= dst_d;
		left_q  <= left_d;
		n_q     <= n_d;
		r_q     <= r_d;
		base_q  <= base_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		idx_q   <= idx_d;
		ph_q    <= ph_d;
		jmag_q  <= jmag_d;
		jneg_q  <= jneg_d;
		bit_q   <= bit_d;
		if (rsp_load) begin
			status_q    <= st_q;
			depth_q     <= count_q;
			top_valid_q <= (count_q != '0);
			top_type_q  <= (count_q != '0) ? rd_t : T_NULL;
			top_value_q <= (count_q != '0) ? rd_v : {VW{1'b0}};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign depth     = depth_q;
	assign top_valid = top_valid_q;
	assign top_type  = top_type_q;
	assign top_value = top_value_q;

`ifndef SYNTH
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCount)
		else $error("stack depth beyond capacity");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> state_q == S_OP)
		else $error("accepted command did not start the sequencer");

	a_top_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> top_valid == (depth != '0))
		else $error("top_valid disagrees with depth");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !top_valid |-> top_type == T_NULL && top_value == '0)
		else $error("empty stack reports a top item");
`endif

endmodule
